@@ design/bti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg
// Types and constants for the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_METAL = 2'd0,
        ACT_LOAD_AGE   = 2'd1,
        ACT_LOAD_LUM   = 2'd2,
        ACT_QUERY      = 2'd3
    } t_action;

    localparam logic CFG_METAL_POINTS = 1'b0;
    localparam logic CFG_AGE_POINTS   = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        t_action            action;
        logic [11:0]        address;
        logic [31:0]        load_value;
        logic signed [15:0] log_metal;
        logic signed [15:0] log_age;
        logic [1:0]         bin;
    } t_in_item;

    typedef struct packed {
        logic [31:0] luminosity;
        logic [3:0]  metal_index;
        logic [5:0]  age_index;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AX_RD0,
        S_AX_CHK0,
        S_AX_CHKN,
        S_AX_SCAN,
        S_AX_DIV,
        S_BASE,
        S_LUM,
        S_MAC,
        S_PUT
    } t_state;

endpackage

@@ design/bti_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_div
// Restoring divider, one quotient bit per cycle: q = floor(num * 2^16 / den),
// valid for num < den.
// ----------------------------------------------------------------------------
module bti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [15:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [16:0] shifted;
    logic        take;

    assign shifted = {r_rem, 1'b0};
    assign take    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 5'd16;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= 16'd0;
        end else if (r_cnt != 5'd0) begin
            // remainder stays below den so 16 bits hold it
            r_rem  <= take ? 16'(shifted - {1'b0, r_den}) : shifted[15:0];
            r_quot <= {r_quot[14:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ design/bilinear_table_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Two breakpoint axes and a luminosity table in block memories; a query finds
// the segment and weight on each axis and blends the four corner words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  a load beat does not make the block busy; a query runs per axis the end
//  checks and, for a point inside, a scan over the segments and a divider run,
//  then the corner reads, the products on the shared 17x32 multiplier and a
//  hand-off to the output register
//  o_in_stall is high for the whole query; a waiting result does not block loads
//  reset clears control and point counts only; memories hold garbage until loaded
// ----------------------------------------------------------------------------
module bilinear_table_interpolator #(
    parameter int MAX_METAL = 16,
    parameter int MAX_AGE   = 64,
    parameter int BINS      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bti_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bti_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [6:0]          i_cfg_data
);
    import bti_pkg::*;

    localparam int DEPTH = MAX_METAL * MAX_AGE * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $clog2(MAX_METAL);
    localparam int GW    = $clog2(MAX_AGE);
    localparam int MAXP  = (MAX_METAL > MAX_AGE) ? MAX_METAL : MAX_AGE;
    localparam int PW    = $clog2(MAXP + 1);
    localparam int BNW   = (BINS > 1) ? $clog2(BINS) : 1;

    logic [15:0] metal_mem [MAX_METAL];
    logic [15:0] age_mem   [MAX_AGE];
    logic [31:0] lum_mem   [DEPTH];

    t_state r_state, n_state;

    logic [4:0]  r_metal_points;
    logic [6:0]  r_age_points;
    logic [PW-1:0] r_nm, r_na;
    logic [BNW-1:0] r_bin;
    logic signed [15:0] r_xm, r_xa;
    logic        r_axis;
    logic [PW-1:0] r_k;
    logic [15:0] r_prev;
    logic [15:0] r_metal_rd, r_age_rd;
    logic [31:0] r_lum_rd;
    logic [MW-1:0] r_seg_m;
    logic [GW-1:0] r_seg_a;
    logic [16:0] r_w_m, r_w_a;
    logic [AW-1:0] r_base, r_row_off;
    logic [2:0]  r_cnt;
    logic [31:0] r_l00, r_l01, r_l10, r_l11;
    logic [2:0]  r_step;
    logic        r_phase;
    logic [48:0] r_prod;
    logic [48:0] r_acc_a;
    logic [63:0] r_total;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        accept;
    logic [PW-1:0] rd_addr;
    logic [AW-1:0] lum_addr;
    logic [15:0] axis_rd;
    logic signed [15:0] x_cur;
    logic [PW-1:0] n_cur;
    logic        fin;
    logic [PW-1:0] fin_seg;
    logic [16:0] fin_w;
    logic        div_start, div_done;
    logic [15:0] div_num, div_den, div_quot;
    logic        seg_hit;
    logic [16:0] mul_w;
    logic [31:0] mul_l;
    logic [31:0] clamp_m, clamp_a, base_c, bin_c;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign axis_rd    = r_axis ? r_age_rd : r_metal_rd;
    assign x_cur      = r_axis ? r_xa : r_xm;
    assign n_cur      = r_axis ? r_na : r_nm;
    assign seg_hit    = ($signed(r_prev) <= x_cur) && (x_cur < $signed(axis_rd));
    assign div_num    = 16'(x_cur - $signed(r_prev));
    assign div_den    = 16'($signed(axis_rd) - $signed(r_prev));

    // point count and bin clamps, and the corner base address
    always_comb begin
        clamp_m = {27'd0, r_metal_points};
        if (clamp_m < 32'd2) clamp_m = 32'd2;
        if (clamp_m > 32'(MAX_METAL)) clamp_m = 32'(MAX_METAL);
        clamp_a = {25'd0, r_age_points};
        if (clamp_a < 32'd2) clamp_a = 32'd2;
        if (clamp_a > 32'(MAX_AGE)) clamp_a = 32'(MAX_AGE);
        bin_c = {30'd0, i_in_data.bin};
        if (bin_c >= 32'(BINS)) bin_c = 32'(BINS - 1);
        base_c = (32'(r_seg_m) * 32'(r_na) + 32'(r_seg_a)) * BINS + 32'(r_bin);
    end

    bti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state and control
    always_comb begin
        n_state   = r_state;
        rd_addr   = '0;
        fin       = 1'b0;
        fin_seg   = '0;
        fin_w     = 17'd0;
        div_start = 1'b0;
        lum_addr  = r_base;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_data.action == ACT_QUERY) n_state = S_AX_RD0;
            end
            S_AX_RD0: begin
                n_state = S_AX_CHK0;
            end
            S_AX_CHK0: begin
                if (x_cur <= $signed(axis_rd)) begin
                    fin = 1'b1;
                end else begin
                    rd_addr = n_cur - PW'(1);
                    n_state = S_AX_CHKN;
                end
            end
            S_AX_CHKN: begin
                if (x_cur >= $signed(axis_rd)) begin
                    fin     = 1'b1;
                    fin_seg = n_cur - PW'(2);
                    fin_w   = ONE_Q16;
                end else begin
                    rd_addr = PW'(1);
                    n_state = S_AX_SCAN;
                end
            end
            S_AX_SCAN: begin
                if (seg_hit) begin
                    div_start = 1'b1;
                    n_state   = S_AX_DIV;
                end else if (r_k + PW'(2) == n_cur) begin
                    // axis not increasing: no segment found
                    fin = 1'b1;
                end else begin
                    rd_addr = r_k + PW'(2);
                end
            end
            S_AX_DIV: begin
                if (div_done) begin
                    fin     = 1'b1;
                    fin_seg = r_k;
                    fin_w   = {1'b0, div_quot};
                end
            end
            S_BASE: begin
                n_state = S_LUM;
            end
            S_LUM: begin
                case (r_cnt)
                    3'd0:    lum_addr = r_base;
                    3'd1:    lum_addr = r_base + AW'(BINS);
                    3'd2:    lum_addr = r_base + r_row_off;
                    default: lum_addr = r_base + r_row_off + AW'(BINS);
                endcase
                if (r_cnt == 3'd4) n_state = S_MAC;
            end
            S_MAC: begin
                if (r_step == 3'd7 && r_phase) n_state = S_PUT;
            end
            S_PUT: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) n_state = r_axis ? S_BASE : S_AX_RD0;
    end

    // multiplier operand select
    always_comb begin
        case (r_step[1:0])
            2'd0:    mul_w = ONE_Q16 - r_w_a;
            2'd1:    mul_w = r_w_a;
            default: mul_w = r_step[2] ? r_w_m : ONE_Q16 - r_w_m;
        endcase
        case (r_step[1:0])
            2'd0:    mul_l = r_step[2] ? r_l10 : r_l00;
            2'd1:    mul_l = r_step[2] ? r_l11 : r_l01;
            2'd2:    mul_l = r_acc_a[31:0];
            default: mul_l = {15'd0, r_acc_a[48:32]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_metal_points <= 5'd2;
            r_age_points   <= 7'd2;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_METAL_POINTS) r_metal_points <= i_cfg_data[4:0];
                if (i_cfg_index == CFG_AGE_POINTS) r_age_points <= i_cfg_data;
            end
            if (r_state == S_PUT && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.action == ACT_LOAD_METAL
                && {20'd0, i_in_data.address} < 32'(MAX_METAL)) begin
            metal_mem[i_in_data.address[MW-1:0]] <= i_in_data.load_value[15:0];
        end
        r_metal_rd <= metal_mem[rd_addr[MW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.action == ACT_LOAD_AGE
                && {20'd0, i_in_data.address} < 32'(MAX_AGE)) begin
            age_mem[i_in_data.address[GW-1:0]] <= i_in_data.load_value[15:0];
        end
        r_age_rd <= age_mem[rd_addr[GW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.action == ACT_LOAD_LUM
                && {20'd0, i_in_data.address} < 32'(DEPTH)) begin
            lum_mem[i_in_data.address[AW-1:0]] <= i_in_data.load_value;
        end
        r_lum_rd <= lum_mem[lum_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_nm    <= PW'(clamp_m);
                r_na    <= PW'(clamp_a);
                r_bin   <= BNW'(bin_c);
                r_xm    <= i_in_data.log_metal;
                r_xa    <= i_in_data.log_age;
                r_axis  <= 1'b0;
                r_total <= 64'd0;
                r_cnt   <= 3'd0;
                r_step  <= 3'd0;
                r_phase <= 1'b0;
            end
            S_AX_CHK0: begin
                r_prev <= axis_rd;
                r_k    <= '0;
            end
            S_AX_SCAN: begin
                if (!seg_hit) begin
                    r_prev <= axis_rd;
                    r_k    <= r_k + PW'(1);
                end
            end
            S_BASE: begin
                r_base    <= AW'(base_c);
                r_row_off <= AW'(32'(r_na) * BINS);
            end
            S_LUM: begin
                r_cnt <= r_cnt + 3'd1;
                case (r_cnt)
                    3'd1:    r_l00 <= r_lum_rd;
                    3'd2:    r_l01 <= r_lum_rd;
                    3'd3:    r_l10 <= r_lum_rd;
                    3'd4:    r_l11 <= r_lum_rd;
                    default: ;
                endcase
            end
            S_MAC: begin
                r_phase <= !r_phase;
                if (!r_phase) begin
                    r_prod <= 49'(mul_w) * 49'(mul_l);
                end else begin
                    r_step <= r_step + 3'd1;
                    case (r_step[1:0])
                        2'd0:    r_acc_a <= r_prod;
                        2'd1:    r_acc_a <= r_acc_a + r_prod;
                        2'd2:    r_total <= r_total + 64'(r_prod);
                        default: r_total <= r_total + {r_prod[31:0], 32'd0};
                    endcase
                end
            end
            S_PUT: begin
                if (n_state == S_IDLE) begin
                    r_out.luminosity  <= r_total[63:32];
                    r_out.metal_index <= 4'(32'(r_seg_m));
                    r_out.age_index   <= 6'(32'(r_seg_a));
                end
            end
            default: ;
        endcase
        if (fin) begin
            r_axis <= 1'b1;
            if (!r_axis) begin
                r_seg_m <= MW'(fin_seg);
                r_w_m   <= fin_w;
            end else begin
                r_seg_a <= GW'(fin_seg);
                r_w_a   <= fin_w;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/bti_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks for the bilinear table interpolator.
// ----------------------------------------------------------------------------
module bti_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input bti_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bti_pkg::t_out_item o_out_data
);
    import bti_pkg::*;

    // a result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // a query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.action == ACT_QUERY |=> o_in_stall)
        else $error("input not stalled after query");

    // a load never produces a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.action != ACT_QUERY
        && !o_out_valid |=> !o_out_valid)
        else $error("result after load beat");

    // results only come out of a busy query
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without query in flight");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ tb/sv/bilinear_table_interpolator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_tb
// Self-checking bench for the bilinear table interpolator. It fills both axes
// and the luminosity words each query needs, then sends directed and random
// loads and queries under random gaps and output back-pressure. It computes
// every lookup in a local copy of the tables and checks each result beat in
// order.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator_tb;
    import bti_pkg::*;

    localparam int N_METAL     = 16;
    localparam int N_AGE       = 64;
    localparam int N_BINS      = 4;
    localparam int LUM_DEPTH   = N_METAL * N_AGE * N_BINS;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 10000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [6:0] i_cfg_data;

    bilinear_table_interpolator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the block's tables and point counts
    logic [15:0] metal_ax [N_METAL];
    logic [15:0] age_ax   [N_AGE];
    logic [31:0] lum_mem  [LUM_DEPTH];
    bit          lum_written [LUM_DEPTH];
    logic [4:0]  metal_cnt;
    logic [6:0]  age_cnt;

    t_out_item lookup_q[$];
    int        errors = 0;
    int        cycles = 0;
    bit        gaps_on = 1'b1;
    bit        long_hold = 1'b0;
    bit        running = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int axis_pt(bit is_metal, int k);
        if (is_metal) return int'($signed(metal_ax[k]));
        return int'($signed(age_ax[k]));
    endfunction

    function automatic void find_segment(input bit is_metal, input int n, input int x,
                                         output int seg, output longint wt);
        int     k, lo, hi;
        longint num;
        seg = 0;
        wt  = 0;
        if (x <= axis_pt(is_metal, 0)) return;
        if (x >= axis_pt(is_metal, n - 1)) begin
            seg = n - 2;
            wt  = 65536;
            return;
        end
        for (k = 0; k + 1 < n; k++) begin
            lo = axis_pt(is_metal, k);
            hi = axis_pt(is_metal, k + 1);
            if (lo <= x && x < hi) begin
                num = longint'(x - lo) << 16;
                wt  = num / longint'(hi - lo);
                seg = k;
                return;
            end
        end
    endfunction

    function automatic int clamp_cnt(int v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_out_item interpolate(t_in_item it);
        int              nm, na, im, ja, base;
        longint          wm, wa;
        longint unsigned l00, l01, l10, l11, a0, a1, total;
        t_out_item       r;
        nm = clamp_cnt(int'(metal_cnt), N_METAL);
        na = clamp_cnt(int'(age_cnt), N_AGE);
        find_segment(1'b1, nm, int'(it.log_metal), im, wm);
        find_segment(1'b0, na, int'(it.log_age), ja, wa);
        base = (im * na + ja) * N_BINS + int'(it.bin);
        l00 = lum_mem[base];
        l01 = lum_mem[base + N_BINS];
        l10 = lum_mem[base + N_BINS * na];
        l11 = lum_mem[base + N_BINS * na + N_BINS];
        a0 = longint'(65536 - wa) * l00 + longint'(wa) * l01;
        a1 = longint'(65536 - wa) * l10 + longint'(wa) * l11;
        total = longint'(65536 - wm) * a0 + longint'(wm) * a1;
        r.luminosity  = total[63:32];
        r.metal_index = im[3:0];
        r.age_index   = ja[5:0];
        return r;
    endfunction

    function automatic void absorb_item(t_in_item it);
        case (it.action)
            ACT_LOAD_METAL: if (it.address < N_METAL) metal_ax[it.address] = it.load_value[15:0];
            ACT_LOAD_AGE:   if (it.address < N_AGE) age_ax[it.address] = it.load_value[15:0];
            ACT_LOAD_LUM: begin
                lum_mem[it.address]     = it.load_value;
                lum_written[it.address] = 1'b1;
            end
            default:        lookup_q.push_back(interpolate(it));
        endcase
    endfunction

    task automatic send_item(t_in_item it);
        int n;
        n = gaps_on ? $urandom_range(0, 14) : 0;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        absorb_item(it);
    endtask

    function automatic t_in_item noise_item(t_action act);
        t_in_item it;
        it = t_in_item'(80'({$urandom, $urandom, $urandom}));
        it.action = act;
        return it;
    endfunction

    task automatic send_load(t_action act, int addr, logic [31:0] val);
        t_in_item it;
        it = noise_item(act);
        it.address    = addr[11:0];
        it.load_value = val;
        send_item(it);
    endtask

    // load any corner word the query reads that has not been written yet
    task automatic prime_corners(t_in_item it);
        int     nm, na, im, ja, base;
        longint wm, wa;
        int     corner [4];
        nm = clamp_cnt(int'(metal_cnt), N_METAL);
        na = clamp_cnt(int'(age_cnt), N_AGE);
        find_segment(1'b1, nm, int'(it.log_metal), im, wm);
        find_segment(1'b0, na, int'(it.log_age), ja, wa);
        base = (im * na + ja) * N_BINS + int'(it.bin);
        corner[0] = base;
        corner[1] = base + N_BINS;
        corner[2] = base + N_BINS * na;
        corner[3] = base + N_BINS * na + N_BINS;
        for (int c = 0; c < 4; c++) begin
            if (!lum_written[corner[c]]) send_load(ACT_LOAD_LUM, corner[c], $urandom);
        end
    endtask

    task automatic send_query(int xm, int xa, int b);
        t_in_item it;
        it = noise_item(ACT_QUERY);
        it.log_metal = xm[15:0];
        it.log_age   = xa[15:0];
        it.bin       = b[1:0];
        prime_corners(it);
        send_item(it);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [6:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_METAL_POINTS) metal_cnt = val[4:0];
        else age_cnt = val;
    endtask

    // strictly increasing axes, sometimes with one-lsb spacing
    task automatic load_axes();
        int v, step;
        step = ($urandom_range(0, 3) == 0) ? 3 : 3800;
        v = -32768 + $urandom_range(0, 4000);
        for (int k = 0; k < N_METAL; k++) begin
            send_load(ACT_LOAD_METAL, k, {$urandom} << 16 | 32'(v[15:0]));
            v += $urandom_range(1, step);
        end
        step = ($urandom_range(0, 3) == 0) ? 3 : 900;
        v = -32768 + $urandom_range(0, 4000);
        for (int k = 0; k < N_AGE; k++) begin
            send_load(ACT_LOAD_AGE, k, {$urandom} << 16 | 32'(v[15:0]));
            v += $urandom_range(1, step);
        end
    endtask

    function automatic int pick_coord(bit is_metal, int n);
        int v;
        case ($urandom_range(0, 5))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = int'($signed(16'($urandom)));
            default: v = axis_pt(is_metal, $urandom_range(0, n - 1)) + $urandom_range(0, 6) - 3;
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v;
    endfunction

    task automatic send_random_query();
        send_query(pick_coord(1'b1, clamp_cnt(int'(metal_cnt), N_METAL)),
                   pick_coord(1'b0, clamp_cnt(int'(age_cnt), N_AGE)),
                   $urandom_range(0, 3));
    endtask

    task automatic send_random_item();
        int k, lo, hi;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: send_random_query();
            8, 9, 10, 11: send_load(ACT_LOAD_LUM, $urandom_range(0, LUM_DEPTH - 1), $urandom);
            12, 13: begin
                // rewrite one metal point between its neighbors
                k  = $urandom_range(0, N_METAL - 1);
                lo = (k == 0) ? -32768 : axis_pt(1'b1, k - 1) + 1;
                hi = (k == N_METAL - 1) ? 32767 : axis_pt(1'b1, k + 1) - 1;
                if (lo <= hi) send_load(ACT_LOAD_METAL, k, 32'($urandom_range(0, hi - lo) + lo));
            end
            14, 15: begin
                k  = $urandom_range(0, N_AGE - 1);
                lo = (k == 0) ? -32768 : axis_pt(1'b0, k - 1) + 1;
                hi = (k == N_AGE - 1) ? 32767 : axis_pt(1'b0, k + 1) - 1;
                if (lo <= hi) send_load(ACT_LOAD_AGE, k, 32'($urandom_range(0, hi - lo) + lo));
            end
            16: send_load(ACT_LOAD_METAL, $urandom_range(N_METAL, 4095), $urandom);
            17: send_load(ACT_LOAD_AGE, $urandom_range(N_AGE, 4095), $urandom);
            18: send_item(noise_item(ACT_LOAD_METAL));
            default: send_item(noise_item(ACT_LOAD_AGE));
        endcase
    endtask

    task automatic test_fill();
        gaps_on = 1'b0;
        load_axes();
        gaps_on = 1'b1;
    endtask

    task automatic test_directed();
        write_cfg(CFG_METAL_POINTS, 7'd2);
        write_cfg(CFG_AGE_POINTS, 7'd2);
        // all-ones corners give the largest blend
        for (int a = 0; a < 16; a++) send_load(ACT_LOAD_LUM, a, 32'hFFFF_FFFF);
        send_query(axis_pt(1'b1, 0) + 1, axis_pt(1'b0, 0) + 1, 3);
        send_query(-32768, -32768, 0);
        send_query(32767, 32767, 3);
        send_query(axis_pt(1'b1, 0), axis_pt(1'b0, 1), 1);
        send_query(axis_pt(1'b1, 1) - 1, axis_pt(1'b0, 1) - 1, 2);
        send_load(ACT_LOAD_LUM, 0, 32'h0);
        send_query(axis_pt(1'b1, 0) + 7, axis_pt(1'b0, 0) + 9, 0);
        // writes past the axis depth are dropped
        send_load(ACT_LOAD_METAL, N_METAL, 32'h0000_7FFF);
        send_load(ACT_LOAD_AGE, 4095, 32'h0000_8000);
        write_cfg(CFG_METAL_POINTS, 7'd16);
        write_cfg(CFG_AGE_POINTS, 7'd64);
        send_query(axis_pt(1'b1, 15), axis_pt(1'b0, 63), 3);
        send_query(axis_pt(1'b1, 7), axis_pt(1'b0, 40) - 1, 1);
        // counts outside the legal range clamp
        write_cfg(CFG_METAL_POINTS, 7'd0);
        write_cfg(CFG_AGE_POINTS, 7'd127);
        send_query(axis_pt(1'b1, 1) - 1, 32767, 2);
        write_cfg(CFG_METAL_POINTS, 7'd31);
        write_cfg(CFG_AGE_POINTS, 7'd1);
        send_query(32767, axis_pt(1'b0, 1) - 2, 0);
        // axis that is not increasing
        write_cfg(CFG_METAL_POINTS, 7'd4);
        send_load(ACT_LOAD_METAL, 1, 32'h0000_7000);
        send_load(ACT_LOAD_METAL, 2, 32'h0000_9000);
        send_query(16'sh6000, 0, 1);
        send_query(16'sh7800, 0, 2);
        wait_idle();
        load_axes();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            if ($urandom_range(0, 3) == 0) write_cfg(CFG_METAL_POINTS, 7'($urandom));
            else write_cfg(CFG_METAL_POINTS, 7'($urandom_range(0, 6)));
            if ($urandom_range(0, 3) == 0) write_cfg(CFG_AGE_POINTS, 7'($urandom));
            else write_cfg(CFG_AGE_POINTS, 7'($urandom_range(0, 10)));
            gaps_on = (p % 4 != 3);
            if (p % 3 == 2) load_axes();
            for (int i = 0; i < per_phase; i++) send_random_item();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_cfg(CFG_METAL_POINTS, 7'd3);
        write_cfg(CFG_AGE_POINTS, 7'd3);
        gaps_on   = 1'b0;
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++) send_random_item();
        // sender waits for every result before going on
        wait_idle();
        for (int i = 0; i < 30; i++) send_random_item();
        gaps_on = 1'b1;
    endtask

    // receiver stall: random hold per beat, or one long hold when asked
    initial begin
        int n;
        @(posedge running);
        forever begin
            if (long_hold) begin
                n = 400;
                long_hold = 1'b0;
            end else begin
                n = $urandom_range(0, 14);
            end
            repeat (n) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid || i_out_stall);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lookup_q.size() == 0) begin
                $display("%0t unexpected result beat, expected none got %h", $time, o_out_data);
                errors++;
            end else begin
                exp_r = lookup_q.pop_front();
                if (o_out_data.luminosity !== exp_r.luminosity) begin
                    $display("%0t luminosity mismatch: expected %h got %h", $time,
                             exp_r.luminosity, o_out_data.luminosity);
                    errors++;
                end
                if (o_out_data.metal_index !== exp_r.metal_index) begin
                    $display("%0t metal_index mismatch: expected %0d got %0d", $time,
                             exp_r.metal_index, o_out_data.metal_index);
                    errors++;
                end
                if (o_out_data.age_index !== exp_r.age_index) begin
                    $display("%0t age_index mismatch: expected %0d got %0d", $time,
                             exp_r.age_index, o_out_data.age_index);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_METAL_POINTS;
        i_cfg_data  <= '0;
        metal_cnt   = 5'd2;
        age_cnt     = 7'd2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        @(posedge i_clk);
        test_fill();
        test_directed();
        test_random(10, 80);
        test_backpressure();
        wait_idle();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/bti_pkg.sv
design/bti_div.sv
design/bilinear_table_interpolator.sv
design/bti_checker.sv
tb/sv/bilinear_table_interpolator_tb.sv
